FILE: design/bfsa_pkg.sv
// ----------------------------------------------------------------------------
// bfsa_pkg
// Shared types, constants and the control store of the BFS traversal unit.
// ----------------------------------------------------------------------------
package bfsa_pkg;

    // Graph size and field widths.
    localparam int VERTEX_COUNT = 8;
    localparam int VERTEX_W     = $clog2(VERTEX_COUNT);
    localparam int ROW_INDEX_W  = 3;
    localparam int ROW_BITS_W   = 8;

    typedef logic [VERTEX_W-1:0]     vertex_t;
    typedef logic [VERTEX_COUNT-1:0] row_t;

    // Input opcodes.
    localparam logic OPC_LOAD = 1'b0;
    localparam logic OPC_RUN  = 1'b1;

    // Control store addresses.
    typedef enum logic [2:0] {
        STEP_IDLE  = 3'd0,
        STEP_START = 3'd1,
        STEP_POP   = 3'd2,
        STEP_SCAN  = 3'd3,
        STEP_NEXT  = 3'd4
    } step_t;

    // Datapath operation selected by a control word.
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_START,
        OP_POP,
        OP_SCAN,
        OP_NEXT
    } op_t;

    // Branch condition selected by a control word.
    typedef enum logic [2:0] {
        COND_RUN_REQ,
        COND_VISITED_S,
        COND_QUEUE_EMPTY,
        COND_W_LAST,
        COND_S_LAST
    } cond_t;

    // One control word: operation, branch condition, taken and fall-through targets.
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jump;
        step_t seq;
    } ctrl_t;

    // Status flags reported by the datapath to the sequencer.
    typedef struct packed {
        logic run_req;
        logic visited_s;
        logic queue_empty;
        logic w_last;
        logic s_last;
        logic stall;
    } status_t;

    // Microprogram. Each step branches to jump when its condition holds.
    function automatic ctrl_t ucode_rom(input step_t step);
        ctrl_t word;
        unique case (step)
            STEP_IDLE:  word = '{OP_IDLE,  COND_RUN_REQ,     STEP_START, STEP_IDLE};
            STEP_START: word = '{OP_START, COND_VISITED_S,   STEP_NEXT,  STEP_POP};
            STEP_POP:   word = '{OP_POP,   COND_QUEUE_EMPTY, STEP_NEXT,  STEP_SCAN};
            STEP_SCAN:  word = '{OP_SCAN,  COND_W_LAST,      STEP_POP,   STEP_SCAN};
            STEP_NEXT:  word = '{OP_NEXT,  COND_S_LAST,      STEP_IDLE,  STEP_START};
            default:    word = '{OP_IDLE,  COND_RUN_REQ,     STEP_START, STEP_IDLE};
        endcase
        return word;
    endfunction

endpackage

FILE: design/bfs_adjacency_matrix_traversal_unit.sv
// ----------------------------------------------------------------------------
// bfs_adjacency_matrix_traversal_unit
// Breadth-first traversal over an 8-vertex adjacency bit matrix, run by a
// microcoded sequencer.
// ----------------------------------------------------------------------------
//  Channel   Direction  Ports                                    Carries
//  s_        in         s_opcode, s_row_index, s_row_bits        row load or run
//  m_        out        m_vertex, m_component_start, m_last      one visited vertex
//
//  A run transaction keeps the sequencer busy after it is accepted: a start
//  and an advance step per vertex, a pop and N scan steps per dequeued vertex,
//  and one pop per search that finds the queue empty. Reset, taken on the
//  clock edge, clears the matrix, marks and step counter.
//  A result waiting in the output register stalls the sequencer only when
//  another vertex must be emitted.
// ----------------------------------------------------------------------------
module bfs_adjacency_matrix_traversal_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_opcode,
    input  logic [bfsa_pkg::ROW_INDEX_W-1:0]     s_row_index,
    input  logic [bfsa_pkg::ROW_BITS_W-1:0]      s_row_bits,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [bfsa_pkg::VERTEX_W-1:0]        m_vertex,
    output logic                                 m_component_start,
    output logic                                 m_last
);
    import bfsa_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    // Input is taken only in the idle step.
    assign s_ready = (ctrl.op == OP_IDLE);

    bfsa_ucode_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    bfsa_datapath u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ctrl              (ctrl),
        .status            (status),
        .s_valid           (s_valid),
        .s_opcode          (s_opcode),
        .s_row_index       (s_row_index),
        .s_row_bits        (s_row_bits),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_vertex          (m_vertex),
        .m_component_start (m_component_start),
        .m_last            (m_last)
    );

endmodule

FILE: design/bfsa_ucode_seq.sv
// ----------------------------------------------------------------------------
// bfsa_ucode_seq
// Step counter and control store; selects the next step from a status flag, or holds it on a stall.
// ----------------------------------------------------------------------------
module bfsa_ucode_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  bfsa_pkg::status_t status,
    output bfsa_pkg::ctrl_t   ctrl
);
    import bfsa_pkg::*;

    step_t pc_reg;
    step_t pc_next;
    logic  cond_true;

    // Control word for the current step.
    assign ctrl = ucode_rom(pc_reg);

    // Condition multiplexer and branch.
    always_comb begin
        unique case (ctrl.cond)
            COND_RUN_REQ:     cond_true = status.run_req;
            COND_VISITED_S:   cond_true = status.visited_s;
            COND_QUEUE_EMPTY: cond_true = status.queue_empty;
            COND_W_LAST:      cond_true = status.w_last;
            COND_S_LAST:      cond_true = status.s_last;
            default:          cond_true = 1'b0;
        endcase
        if (status.stall) begin
            pc_next = pc_reg;
        end else if (cond_true) begin
            pc_next = ctrl.jump;
        end else begin
            pc_next = ctrl.seq;
        end
    end

    // Step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

FILE: design/bfsa_datapath.sv
// ----------------------------------------------------------------------------
// bfsa_datapath
// Adjacency matrix, visited marks, vertex queue, scan counters and the
// result register, all driven by the current control word.
// ----------------------------------------------------------------------------
module bfsa_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  bfsa_pkg::ctrl_t                      ctrl,
    output bfsa_pkg::status_t                    status,
    input  logic                                 s_valid,
    input  logic                                 s_opcode,
    input  logic [bfsa_pkg::ROW_INDEX_W-1:0]     s_row_index,
    input  logic [bfsa_pkg::ROW_BITS_W-1:0]      s_row_bits,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [bfsa_pkg::VERTEX_W-1:0]        m_vertex,
    output logic                                 m_component_start,
    output logic                                 m_last
);
    import bfsa_pkg::*;

    localparam vertex_t LAST_VERTEX = vertex_t'(VERTEX_COUNT - 1);

    row_t    adj_reg [VERTEX_COUNT];
    vertex_t queue_mem [VERTEX_COUNT];
    row_t    visited_reg;
    vertex_t head_reg;
    vertex_t tail_reg;
    vertex_t s_reg;
    vertex_t w_reg;
    vertex_t u_reg;
    vertex_t cnt_reg;
    logic    out_valid_reg;
    vertex_t out_vertex_reg;
    logic    out_start_reg;
    logic    out_last_reg;

    logic    load_en;
    logic    run_en;
    logic    scan_hit;
    logic    emit_req;
    logic    stall;
    logic    emit_en;
    vertex_t emit_vertex;
    logic    emit_start;

    // Decode of the current operation.
    always_comb begin
        load_en  = (ctrl.op == OP_IDLE) && s_valid && (s_opcode == OPC_LOAD);
        run_en   = (ctrl.op == OP_IDLE) && s_valid && (s_opcode == OPC_RUN);
        scan_hit = adj_reg[u_reg][w_reg] && !visited_reg[w_reg];
        emit_req = ((ctrl.op == OP_START) && !visited_reg[s_reg])
                || ((ctrl.op == OP_SCAN) && scan_hit);
        stall    = emit_req && out_valid_reg && !m_ready;
        emit_en  = emit_req && !stall;
        emit_vertex = (ctrl.op == OP_START) ? s_reg : w_reg;
        emit_start  = (ctrl.op == OP_START);
    end

    // Status back to the sequencer.
    assign status = '{
        run_req:     run_en,
        visited_s:   visited_reg[s_reg],
        queue_empty: (head_reg == tail_reg),
        w_last:      (w_reg == LAST_VERTEX),
        s_last:      (s_reg == LAST_VERTEX),
        stall:       stall
    };

    // Adjacency rows: one row written per load transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < VERTEX_COUNT; i++) begin
                adj_reg[i] <= '0;
            end
        end else if (load_en && (int'(s_row_index) < VERTEX_COUNT)) begin
            adj_reg[s_row_index[VERTEX_W-1:0]] <= s_row_bits[VERTEX_COUNT-1:0];
        end
    end

    // Vertex queue: the root written at slot 0, others at the tail; read into u at the head.
    always_ff @(posedge aclk) begin
        if ((ctrl.op == OP_START) && emit_en) begin
            queue_mem[0] <= s_reg;
        end else if ((ctrl.op == OP_SCAN) && emit_en) begin
            queue_mem[tail_reg] <= w_reg;
        end
        if (ctrl.op == OP_POP) begin
            u_reg <= queue_mem[head_reg];
        end
    end

    // Traversal control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            visited_reg <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            s_reg       <= '0;
            w_reg       <= '0;
            cnt_reg     <= '0;
        end else begin
            unique case (ctrl.op)
                OP_IDLE: begin
                    if (run_en) begin
                        visited_reg <= '0;
                        s_reg       <= '0;
                        cnt_reg     <= '0;
                    end
                end
                OP_START: begin
                    if (emit_en) begin
                        visited_reg[s_reg] <= 1'b1;
                        head_reg <= '0;
                        tail_reg <= vertex_t'(1);
                    end
                end
                OP_POP: begin
                    if (head_reg != tail_reg) begin
                        head_reg <= (head_reg == LAST_VERTEX) ? '0 : head_reg + 1'b1;
                        w_reg    <= '0;
                    end
                end
                OP_SCAN: begin
                    if (emit_en) begin
                        visited_reg[w_reg] <= 1'b1;
                        tail_reg <= (tail_reg == LAST_VERTEX) ? '0 : tail_reg + 1'b1;
                    end
                    if (!stall) begin
                        w_reg <= (w_reg == LAST_VERTEX) ? '0 : w_reg + 1'b1;
                    end
                end
                OP_NEXT: begin
                    s_reg <= (s_reg == LAST_VERTEX) ? '0 : s_reg + 1'b1;
                end
                default: begin
                end
            endcase
            if (emit_en) begin
                cnt_reg <= (cnt_reg == LAST_VERTEX) ? '0 : cnt_reg + 1'b1;
            end
        end
    end

    // Result register: holds one transaction until the sink takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_en) begin
            out_vertex_reg <= emit_vertex;
            out_start_reg  <= emit_start;
            out_last_reg   <= (cnt_reg == LAST_VERTEX);
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_vertex          = out_vertex_reg;
    assign m_component_start = out_start_reg;
    assign m_last            = out_last_reg;

endmodule

FILE: design/bfsa_checker.sv
// ----------------------------------------------------------------------------
// bfsa_checker
// Port-level checks of the BFS traversal unit, bound to the top level.
// ----------------------------------------------------------------------------
module bfsa_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              s_opcode,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [bfsa_pkg::VERTEX_W-1:0]     m_vertex,
    input logic                              m_component_start,
    input logic                              m_last
);
    import bfsa_pkg::*;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result transaction dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_vertex) && $stable(m_component_start)
                                && $stable(m_last))
        else $error("result payload changed while stalled");

    // Accepting a run transaction leaves the idle step.
    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_opcode == OPC_RUN) |=> !s_ready)
        else $error("input accepted during a traversal");

    // Vertex zero is always the root of the first search.
    a_zero_root: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_vertex == '0) |-> m_component_start)
        else $error("vertex zero emitted without component start");

endmodule

bind bfs_adjacency_matrix_traversal_unit bfsa_checker u_bfsa_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .s_opcode          (s_opcode),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_vertex          (m_vertex),
    .m_component_start (m_component_start),
    .m_last            (m_last)
);
